// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the timer setting search block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define CTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define CTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define CTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define CTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared widths, microcode format, program table and prescaler tables.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int DUR_W  = 26;  // input duration width
  localparam int CYC_W  = 33;  // duration * 80
  localparam int IDX_W  = 3;
  localparam int CMP_W  = 8;
  localparam int SCMP_W = 16;
  localparam int PER_W  = 18;  // max period 1024 * 255
  localparam int PROD_W = PER_W + SCMP_W;
  localparam int SH_W   = 4;
  localparam int DCNT_W = 6;   // divider step counter

  localparam logic [IDX_W-1:0]  LAST_INDEX  = 3'd6;
  localparam logic [CMP_W-1:0]  MAX_FIRST   = 8'hFF;
  localparam logic [SCMP_W-1:0] MAX_SECOND  = 16'hFFFF;
  localparam logic [DCNT_W-1:0] DIV_STEPS_M1 = DCNT_W'(CYC_W - 1);

  // program counter and step addresses
  typedef logic [2:0] pc_t;
  localparam pc_t PC_IDLE     = 3'd0;
  localparam pc_t PC_SEARCH   = 3'd1;
  localparam pc_t PC_DIV_INIT = 3'd2;
  localparam pc_t PC_DIV_STEP = 3'd3;
  localparam pc_t PC_EMIT     = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEARCH,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_START,
    C_STOP,
    C_DIV_LAST
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   next_t;  // taken when cond holds
    pc_t   next_f;  // taken otherwise
  } ucw_t;

  // sequencer -> datapath
  typedef struct packed {
    op_t op;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic stop;      // search found a setting or hit the limit
    logic div_last;  // final divider step
  } stat_t;

  // control store
  function automatic ucw_t ucode(input pc_t pc);
    ucw_t w;
    case (pc)
      PC_IDLE:     w = '{op: OP_LOAD,     cond: C_START,    next_t: PC_SEARCH,
                         next_f: PC_IDLE};
      PC_SEARCH:   w = '{op: OP_SEARCH,   cond: C_STOP,     next_t: PC_DIV_INIT,
                         next_f: PC_SEARCH};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_ALWAYS,   next_t: PC_DIV_STEP,
                         next_f: PC_DIV_STEP};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_LAST, next_t: PC_EMIT,
                         next_f: PC_DIV_STEP};
      PC_EMIT:     w = '{op: OP_EMIT,     cond: C_ALWAYS,   next_t: PC_IDLE,
                         next_f: PC_IDLE};
      default:     w = '{op: OP_NONE,     cond: C_ALWAYS,   next_t: PC_IDLE,
                         next_f: PC_IDLE};
    endcase
    return w;
  endfunction

  // log2 of prescaler 1,8,32,64,128,256,1024
  function automatic logic [SH_W-1:0] presc_shift(input logic [IDX_W-1:0] idx);
    logic [SH_W-1:0] s;
    case (idx)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd5;
      3'd3:    s = 4'd6;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd8;
      3'd6:    s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // next prescaler / this prescaler
  function automatic logic [CMP_W-1:0] presc_ratio(input logic [IDX_W-1:0] idx);
    logic [CMP_W-1:0] r;
    case (idx)
      3'd0:    r = 8'd8;
      3'd1:    r = 8'd4;
      3'd2:    r = 8'd2;
      3'd3:    r = 8'd2;
      3'd4:    r = 8'd2;
      3'd5:    r = 8'd4;
      default: r = 8'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cts_useq.sv =====
// ----------------------------------------------------------------------------
// cts_useq
// Microcode sequencer: step counter, control store lookup, branch select.
// ----------------------------------------------------------------------------
module cts_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  cts_pkg::stat_t  stat,
  output cts_pkg::ctrl_t  ctrl,
  output logic            busy
);

  cts_pkg::pc_t  pc_r;
  cts_pkg::pc_t  pc_nxt;
  cts_pkg::ucw_t uw;
  logic          cond_hit;

  assign uw   = cts_pkg::ucode(pc_r);
  assign busy = (pc_r != cts_pkg::PC_IDLE);

  always_comb begin
    case (uw.cond)
      cts_pkg::C_ALWAYS:   cond_hit = 1'b1;
      cts_pkg::C_START:    cond_hit = start;
      cts_pkg::C_STOP:     cond_hit = stat.stop;
      cts_pkg::C_DIV_LAST: cond_hit = stat.div_last;
      default:             cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt = cond_hit ? uw.next_t : uw.next_f;
  end

  // load only happens on an accepted item
  always_comb begin
    ctrl.op = uw.op;
    if (uw.op == cts_pkg::OP_LOAD && !start) begin
      ctrl.op = cts_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= cts_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/cts_dp.sv =====
// ----------------------------------------------------------------------------
// cts_dp
// Datapath: cycle count, setting walk, restoring divider, result registers.
// ----------------------------------------------------------------------------
module cts_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cts_pkg::ctrl_t               ctrl,
  input  logic [cts_pkg::DUR_W-1:0]    duration_10us,
  output cts_pkg::stat_t               stat,
  output logic                         res_valid,
  output logic [cts_pkg::IDX_W-1:0]    res_index,
  output logic [cts_pkg::CMP_W-1:0]    res_first,
  output logic [cts_pkg::SCMP_W-1:0]   res_second
);

  localparam int CYC_W  = cts_pkg::CYC_W;
  localparam int PER_W  = cts_pkg::PER_W;
  localparam int PROD_W = cts_pkg::PROD_W;
  localparam int IDX_W  = cts_pkg::IDX_W;
  localparam int CMP_W  = cts_pkg::CMP_W;
  localparam int SCMP_W = cts_pkg::SCMP_W;
  localparam int DCNT_W = cts_pkg::DCNT_W;

  logic [CYC_W-1:0]  cycles_r, cycles_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CMP_W-1:0]  cmp_r, cmp_nxt;
  logic [PER_W-1:0]  rem_r, rem_nxt;
  logic [CYC_W-1:0]  quo_r, quo_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              valid_r, valid_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic [CMP_W-1:0]  ocmp_r, ocmp_nxt;
  logic [SCMP_W-1:0] osec_r, osec_nxt;

  logic [PER_W-1:0]  period;
  logic [PROD_W-1:0] prod;     // period * 65535
  logic              found;
  logic              at_limit;
  logic [PER_W+1:0]  trial;
  logic              ge;

  // period = prescaler * compare, prescaler is a power of two
  assign period   = PER_W'(cmp_r) << cts_pkg::presc_shift(idx_r);
  assign prod     = {period, SCMP_W'(0)} - PROD_W'(period);
  assign found    = prod > PROD_W'(cycles_r);
  assign at_limit = (idx_r == cts_pkg::LAST_INDEX) && (cmp_r >= cts_pkg::MAX_FIRST);

  assign stat.stop     = found || at_limit;
  assign stat.div_last = (dcnt_r == '0);

  // restoring divider trial subtract
  assign trial = {1'b0, rem_r, quo_r[CYC_W-1]} - {2'b00, period};
  assign ge    = !trial[PER_W+1];

  always_comb begin
    cycles_nxt = cycles_r;
    idx_nxt    = idx_r;
    cmp_nxt    = cmp_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    oidx_nxt   = oidx_r;
    ocmp_nxt   = ocmp_r;
    osec_nxt   = osec_r;
    valid_nxt  = 1'b0;
    case (ctrl.op)
      cts_pkg::OP_LOAD: begin
        // x80 = x64 + x16
        cycles_nxt = CYC_W'({duration_10us, 6'b0}) + CYC_W'({duration_10us, 4'b0});
        idx_nxt    = '0;
        cmp_nxt    = CMP_W'(1);
      end
      cts_pkg::OP_SEARCH: begin
        if (!(found || at_limit)) begin
          if (idx_r == cts_pkg::LAST_INDEX) begin
            cmp_nxt = cmp_r + CMP_W'(1);
          end else if (cmp_r < cts_pkg::presc_ratio(idx_r)) begin
            cmp_nxt = cmp_r + CMP_W'(1);
          end else begin
            cmp_nxt = CMP_W'(1);
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      cts_pkg::OP_DIV_INIT: begin
        rem_nxt  = '0;
        quo_nxt  = cycles_r;
        dcnt_nxt = cts_pkg::DIV_STEPS_M1;
      end
      cts_pkg::OP_DIV_STEP: begin
        rem_nxt  = ge ? trial[PER_W-1:0] : {rem_r[PER_W-2:0], quo_r[CYC_W-1]};
        quo_nxt  = {quo_r[CYC_W-2:0], ge};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
      end
      cts_pkg::OP_EMIT: begin
        valid_nxt = 1'b1;
        oidx_nxt  = idx_r;
        ocmp_nxt  = cmp_r;
        osec_nxt  = (quo_r[CYC_W-1:SCMP_W] != '0) ? cts_pkg::MAX_SECOND
                                                  : quo_r[SCMP_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cycles_r <= cycles_nxt;
    idx_r    <= idx_nxt;
    cmp_r    <= cmp_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dcnt_r   <= dcnt_nxt;
    oidx_r   <= oidx_nxt;
    ocmp_r   <= ocmp_nxt;
    osec_r   <= osec_nxt;
  end

  assign res_valid  = valid_r;
  assign res_index  = oidx_r;
  assign res_first  = ocmp_r;
  assign res_second = osec_r;

endmodule

// ===== rtl/cascaded_timer_setting_search.sv =====
// ----------------------------------------------------------------------------
// cascaded_timer_setting_search
// Picks prescaler, first and second compare values for a cascaded timer pair.
// ----------------------------------------------------------------------------
// The search step tries one setting per cycle, 1..277 settings per item, then
//   the 33-step restoring divider runs; a new item is taken only once the
//   sequencer is back at idle.
// busy is low during the strobe cycle, so the next item may start there.
// Reset (synchronous, rst_n low): sequencer returns to idle, strobe cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module cascaded_timer_setting_search (
  input  logic                          clk,
  input  logic                          rst_n,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [cts_pkg::DUR_W-1:0]     in_duration_10us,
  // result side
  output logic                          out_valid,
  output logic [cts_pkg::IDX_W-1:0]     out_prescaler_index,
  output logic [cts_pkg::CMP_W-1:0]     out_first_compare,
  output logic [cts_pkg::SCMP_W-1:0]    out_second_compare
);

  cts_pkg::ctrl_t ctrl;
  cts_pkg::stat_t stat;
  logic           accept;
  logic           out_legal;

  assign accept = start && !busy;

  // nonzero compare, index within the prescaler table
  assign out_legal = (out_first_compare != '0) &&
                     (out_prescaler_index <= cts_pkg::LAST_INDEX);

  // Microcode program (one control word per step):
  //   idle     : wait for start, latch duration*80, walk begins at index 0/cmp 1
  //   search   : test one setting per cycle, advance until period*65535 > cycles
  //              or the last setting (index 6, cmp 255)
  //   div init : seed restoring divider with the cycle count
  //   div step : one quotient bit per cycle, down to the last divider step
  //   emit     : saturate quotient to 16 bits, register outputs with strobe
  cts_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // datapath: holds cycle count, current setting, divider and result regs
  cts_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .duration_10us (in_duration_10us),
    .stat          (stat),
    .res_valid     (out_valid),
    .res_index     (out_prescaler_index),
    .res_first     (out_first_compare),
    .res_second    (out_second_compare)
  );

  // an accepted item keeps the block busy in the following cycle
  `CTS_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy, "busy not raised after accept")
  // strobe only comes once the sequencer is back at idle
  `CTS_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, !busy, "result while busy")
  // one strobe per item, never two in a row
  `CTS_ASSERT_NXT(a_out_single, clk, rst_n, out_valid, !out_valid, "double result strobe")
  // a result always names a legal setting
  `CTS_ASSERT_IMP(a_out_legal, clk, rst_n, out_valid, out_legal, "illegal setting")

endmodule
